// ===== rtl/espc_pkg.sv =====
// espc_pkg: shared types and constants of the encoder speed pi controller
// item payloads, serial multiplier and divider requests, register indexes
// no dependencies
package espc_pkg;

    localparam int ACC_W = 64;
    localparam int MB_W  = 32;
    localparam int NUM_W = 58;
    localparam int DEN_W = 43;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_PROP   = 3'd1;
    localparam logic [2:0] REG_INTEG  = 3'd2;
    localparam logic [2:0] REG_BASE   = 3'd3;
    localparam logic [2:0] REG_WEIGHT = 3'd4;
    localparam logic [2:0] REG_PPR    = 3'd5;

    localparam logic [19:0] PROP_RST   = 20'd786;
    localparam logic [19:0] INTEG_RST  = 20'd4588;
    localparam logic [15:0] BASE_RST   = 16'd44976;
    localparam logic [15:0] WEIGHT_RST = 16'd6554;
    localparam logic [7:0]  PPR_RST    = 8'd20;

    localparam logic [MB_W-1:0]  US_PER_S    = 32'd1000000;
    localparam logic [DEN_W-1:0] HALF_US_DEN = 43'd2000000;
    localparam logic [NUM_W-1:0] PARTIAL_MAX = 58'd49152;
    localparam logic [NUM_W-1:0] RAW_LIM     = 58'd67108864;
    localparam logic [MB_W-1:0]  FREQ_NEW_W  = 32'd26214;
    localparam logic [MB_W-1:0]  FREQ_OLD_W  = 32'd39322;
    localparam logic [ACC_W-1:0] ROUND_HALF  = 64'd32768;
    localparam logic [28:0]      ONE_Q28     = 29'd268435456;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [15:0] drive_duty;
        logic [23:0] freq_estimate;
        logic        clamped;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic             keep;
        logic [ACC_W-1:0] a;
        logic [MB_W-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

endpackage

// ===== rtl/espc_stream_if.sv =====
// espc_stream_if: valid/ready channel carrying one item payload
// payload type is set by the instantiating level
interface espc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/espc_mul.sv =====
// espc_mul: bit-serial multiply-accumulate, one multiplier bit per cycle
// signed 64-bit multiplicand, unsigned 32-bit multiplier; uses espc_pkg
module espc_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  espc_pkg::mul_req_t req,
    output logic [espc_pkg::ACC_W-1:0] acc,
    output logic              done
);
    logic [espc_pkg::ACC_W-1:0] a_reg;
    logic [espc_pkg::MB_W-1:0]  b_reg;
    logic [espc_pkg::ACC_W-1:0] acc_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && b_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            if (!req.keep)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg && b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;
endmodule

// ===== rtl/espc_div.sv =====
// espc_div: restoring divider, one quotient bit per cycle
// 58-bit dividend, 43-bit nonzero divisor; uses espc_pkg
module espc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  espc_pkg::div_req_t req,
    output logic [espc_pkg::NUM_W-1:0] quo,
    output logic              done
);
    localparam int CNT_W = $clog2(espc_pkg::NUM_W);

    logic [espc_pkg::NUM_W-1:0] num_reg;
    logic [espc_pkg::DEN_W-1:0] den_reg;
    logic [espc_pkg::DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [espc_pkg::DEN_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, num_reg[espc_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(espc_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= espc_pkg::DEN_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[espc_pkg::DEN_W-1:0];
            end
            num_reg <= {num_reg[espc_pkg::NUM_W-2:0], fits};
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;
endmodule

// ===== rtl/encoder_speed_pi_controller_core.sv =====
// encoder_speed_pi_controller_core: encoder speed measurement and pi drive loop
// uses espc_pkg, espc_stream_if, espc_mul, espc_div
//
// item_in carries events {mode, now_us}: mode 0 is an encoder rising edge,
// mode 1 a control step. An edge gives no result; a control step gives one
// item on item_out {drive_duty, freq_estimate, clamped}.
// The block takes one item at a time: item_in.ready is high only when idle.
// An edge that updates the interval average runs one serial multiply over the
// 16 weight bits. A control step runs up to three passes of the bit-serial
// divider plus serial multiplies whose length is the bit length of the
// multiplier operand (pulses per revolution, 1e6, smoothing weights, window,
// gains). With no interval average the partial divide is skipped, and a zero
// window skips the rate divide. A finished result sits in the output
// register; the next item is accepted while it waits. A further control step
// that completes while item_out is stalled waits until the register frees.
// Reset loads the register defaults and clears all measurement and loop state.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it.
module encoder_speed_pi_controller_core #(
    parameter int SKIP_LIMIT = 3,
    parameter int DUTY_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    espc_stream_if.sink   item_in,
    espc_stream_if.source item_out,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int LVL_W = 29 + DUTY_BITS;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_EDGE    = 5'd1;
    localparam logic [4:0] ST_E_MUL   = 5'd2;
    localparam logic [4:0] ST_C_START = 5'd3;
    localparam logic [4:0] ST_C_PDIV  = 5'd4;
    localparam logic [4:0] ST_C_CNT   = 5'd5;
    localparam logic [4:0] ST_C_DEN   = 5'd6;
    localparam logic [4:0] ST_C_NUM   = 5'd7;
    localparam logic [4:0] ST_C_RDIV  = 5'd8;
    localparam logic [4:0] ST_C_SM1   = 5'd9;
    localparam logic [4:0] ST_C_SM2   = 5'd10;
    localparam logic [4:0] ST_C_ERR   = 5'd11;
    localparam logic [4:0] ST_C_IMUL  = 5'd12;
    localparam logic [4:0] ST_C_IDIV  = 5'd13;
    localparam logic [4:0] ST_C_PMUL  = 5'd14;
    localparam logic [4:0] ST_C_KMUL  = 5'd15;
    localparam logic [4:0] ST_C_EMIT  = 5'd16;

    // configuration
    logic [23:0] target_reg;
    logic [19:0] prop_reg;
    logic [19:0] kint_reg;
    logic [15:0] base_reg;
    logic [15:0] weight_reg;
    logic [7:0]  ppr_reg;

    // state and working registers
    logic [4:0]         state_reg, state_next;
    logic [31:0]        last_pulse_reg, last_pulse_next;
    logic [39:0]        avg_reg, avg_next;
    logic [1:0]         skip_reg, skip_next;
    logic [15:0]        good_reg, good_next;
    logic [15:0]        prev_part_reg, prev_part_next;
    logic [23:0]        freq_reg, freq_next;
    logic signed [24:0] prev_err_reg, prev_err_next;
    logic signed [39:0] integ_reg, integ_next;
    logic [31:0]        last_step_reg, last_step_next;
    logic [31:0]        now_reg, now_next;
    logic [31:0]        win_reg, win_next;
    logic [15:0]        part_reg, part_next;
    logic               cnt_neg_reg, cnt_neg_next;
    logic [31:0]        cnt_mag_reg, cnt_mag_next;
    logic [42:0]        den_reg, den_next;
    logic signed [24:0] e_reg, e_next;
    logic               sum_neg_reg, sum_neg_next;
    logic signed [39:0] cand_reg, cand_next;
    logic [15:0]        duty_reg, duty_next;
    logic               clamp_reg, clamp_next;
    logic               out_valid_reg, out_valid_next;
    espc_pkg::out_item_t out_reg, out_next;

    espc_pkg::mul_req_t mul_req;
    espc_pkg::div_req_t div_req;
    logic [espc_pkg::ACC_W-1:0] mul_acc;
    logic                       mul_done;
    logic [espc_pkg::NUM_W-1:0] div_q;
    logic                       div_done;

    // datapath terms
    logic [31:0]        elapsed;
    logic               glitch;
    logic [40:0]        avg_diff;
    logic [63:0]        avg_sum;
    logic signed [33:0] cnt_s;
    logic [33:0]        cnt_abs;
    logic [26:0]        raw_mag;
    logic [63:0]        raw_s;
    logic [63:0]        fsum;
    logic signed [24:0] e_s;
    logic signed [25:0] esum;
    logic [25:0]        esum_mag;
    logic signed [41:0] delta;
    logic signed [41:0] cand_w;
    logic signed [39:0] cand_sat;
    logic signed [63:0] tot;
    logic               over;
    logic               under;
    logic [28:0]        accc;
    logic [LVL_W-1:0]   lev_prod;
    logic [15:0]        duty_c;

    espc_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .acc  (mul_acc),
        .done (mul_done)
    );

    espc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .quo  (div_q),
        .done (div_done)
    );

    assign elapsed  = now_reg - last_pulse_reg;
    assign glitch   = {elapsed, 9'b0} < {1'b0, avg_reg};
    assign avg_diff = {1'b0, elapsed, 8'b0} - {1'b0, avg_reg};
    assign avg_sum  = {8'b0, avg_reg, 16'b0} + mul_acc + espc_pkg::ROUND_HALF;

    assign cnt_s   = $signed({3'b0, good_reg, 15'b0}) + $signed({18'b0, part_reg})
                   - $signed({18'b0, prev_part_reg});
    assign cnt_abs = cnt_s[33] ? 34'(-cnt_s) : 34'(cnt_s);

    assign raw_mag = (div_q > espc_pkg::RAW_LIM) ? 27'(espc_pkg::RAW_LIM) : div_q[26:0];
    assign raw_s   = cnt_neg_reg ? 64'(-{37'b0, raw_mag}) : {37'b0, raw_mag};
    assign fsum    = mul_acc + espc_pkg::ROUND_HALF;

    assign e_s      = $signed({1'b0, target_reg}) - $signed({1'b0, freq_reg});
    assign esum     = 26'(e_s) + 26'(prev_err_reg);
    assign esum_mag = esum[25] ? 26'(-esum) : 26'(esum);

    assign delta    = sum_neg_reg ? -$signed(div_q[41:0]) : $signed(div_q[41:0]);
    assign cand_w   = 42'(integ_reg) + delta;
    assign cand_sat = (cand_w > 42'sd549755813887) ? 40'sh7F_FFFF_FFFF
                    : (cand_w < -42'sd549755813888) ? 40'sh80_0000_0000
                    : cand_w[39:0];

    assign tot   = $signed(mul_acc)
                 + ((target_reg != '0) ? $signed({36'b0, base_reg, 12'b0}) : 64'sd0);
    assign over  = tot > $signed({35'b0, espc_pkg::ONE_Q28});
    assign under = tot[63];
    assign accc  = over ? espc_pkg::ONE_Q28 : (under ? 29'd0 : tot[28:0]);

    assign lev_prod = (LVL_W'(accc) << DUTY_BITS) - LVL_W'(accc);
    assign duty_c   = 16'(lev_prod >> 28) << (16 - DUTY_BITS);

    assign item_in.ready    = (state_reg == ST_IDLE);
    assign item_out.valid   = out_valid_reg;
    assign item_out.payload = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        last_pulse_next = last_pulse_reg;
        avg_next        = avg_reg;
        skip_next       = skip_reg;
        good_next       = good_reg;
        prev_part_next  = prev_part_reg;
        freq_next       = freq_reg;
        prev_err_next   = prev_err_reg;
        integ_next      = integ_reg;
        last_step_next  = last_step_reg;
        now_next        = now_reg;
        win_next        = win_reg;
        part_next       = part_reg;
        cnt_neg_next    = cnt_neg_reg;
        cnt_mag_next    = cnt_mag_reg;
        den_next        = den_reg;
        e_next          = e_reg;
        sum_neg_next    = sum_neg_reg;
        cand_next       = cand_reg;
        duty_next       = duty_reg;
        clamp_next      = clamp_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !item_out.ready;
        mul_req         = '0;
        div_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    now_next   = item_in.payload.now_us;
                    state_next = (item_in.payload.mode == espc_pkg::MODE_STEP)
                               ? ST_C_START : ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                last_pulse_next = now_reg;
                state_next      = ST_IDLE;
                if (glitch)
                begin
                    if (skip_reg < 2'(SKIP_LIMIT))
                    begin
                        skip_next = skip_reg + 1'b1;
                    end
                    else
                    begin
                        avg_next = '0;
                    end
                end
                else
                begin
                    skip_next = '0;
                    if (good_reg != 16'hFFFF)
                    begin
                        good_next = good_reg + 1'b1;
                    end
                    if (avg_reg == '0)
                    begin
                        if (last_pulse_reg != '0)
                        begin
                            avg_next = {elapsed, 8'b0};
                        end
                    end
                    else
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = 64'($signed(avg_diff));
                        mul_req.b     = 32'(weight_reg);
                        state_next    = ST_E_MUL;
                    end
                end
            end
            ST_E_MUL:
            begin
                if (mul_done)
                begin
                    avg_next   = avg_sum[55:16];
                    state_next = ST_IDLE;
                end
            end
            ST_C_START:
            begin
                win_next = now_reg - last_step_reg;
                if (avg_reg != '0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = 58'(elapsed) << 23;
                    div_req.den   = 43'(avg_reg);
                    state_next    = ST_C_PDIV;
                end
                else
                begin
                    part_next  = '0;
                    state_next = ST_C_CNT;
                end
            end
            ST_C_PDIV:
            begin
                if (div_done)
                begin
                    part_next  = (div_q > espc_pkg::PARTIAL_MAX) ? 16'd0 : div_q[15:0];
                    state_next = ST_C_CNT;
                end
            end
            ST_C_CNT:
            begin
                cnt_neg_next  = cnt_s[33];
                cnt_mag_next  = cnt_abs[31:0];
                mul_req.start = 1'b1;
                mul_req.a     = 64'(win_reg);
                mul_req.b     = 32'(ppr_reg);
                state_next    = ST_C_DEN;
            end
            ST_C_DEN:
            begin
                if (mul_done)
                begin
                    den_next = {mul_acc[39:0], 3'b0};
                    if (mul_acc[39:0] == '0)
                    begin
                        state_next = ST_C_ERR;
                    end
                    else
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = 64'(cnt_mag_reg);
                        mul_req.b     = espc_pkg::US_PER_S;
                        state_next    = ST_C_NUM;
                    end
                end
            end
            ST_C_NUM:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_acc[57:0];
                    div_req.den   = den_reg;
                    state_next    = ST_C_RDIV;
                end
            end
            ST_C_RDIV:
            begin
                if (div_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = raw_s;
                    mul_req.b     = espc_pkg::FREQ_NEW_W;
                    state_next    = ST_C_SM1;
                end
            end
            ST_C_SM1:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.keep  = 1'b1;
                    mul_req.a     = 64'(freq_reg);
                    mul_req.b     = espc_pkg::FREQ_OLD_W;
                    state_next    = ST_C_SM2;
                end
            end
            ST_C_SM2:
            begin
                if (mul_done)
                begin
                    if (mul_acc[63])
                    begin
                        freq_next = '0;
                    end
                    else if (fsum[63:40] != '0)
                    begin
                        freq_next = 24'hFFFFFF;
                    end
                    else
                    begin
                        freq_next = fsum[39:16];
                    end
                    state_next = ST_C_ERR;
                end
            end
            ST_C_ERR:
            begin
                prev_part_next = part_reg;
                good_next      = '0;
                e_next         = e_s;
                sum_neg_next   = esum[25];
                mul_req.start  = 1'b1;
                mul_req.a      = 64'(esum_mag);
                mul_req.b      = win_reg;
                state_next     = ST_C_IMUL;
            end
            ST_C_IMUL:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_acc[57:0];
                    div_req.den   = espc_pkg::HALF_US_DEN;
                    state_next    = ST_C_IDIV;
                end
            end
            ST_C_IDIV:
            begin
                if (div_done)
                begin
                    cand_next     = cand_sat;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(e_reg);
                    mul_req.b     = 32'(prop_reg);
                    state_next    = ST_C_PMUL;
                end
            end
            ST_C_PMUL:
            begin
                if (mul_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.keep  = 1'b1;
                    mul_req.a     = 64'(cand_reg);
                    mul_req.b     = 32'(kint_reg);
                    state_next    = ST_C_KMUL;
                end
            end
            ST_C_KMUL:
            begin
                if (mul_done)
                begin
                    if (!(over || under))
                    begin
                        integ_next = cand_reg;
                    end
                    clamp_next     = over || under;
                    duty_next      = duty_c;
                    prev_err_next  = e_reg;
                    last_step_next = now_reg;
                    state_next     = ST_C_EMIT;
                end
            end
            ST_C_EMIT:
            begin
                if (!out_valid_reg || item_out.ready)
                begin
                    out_next.drive_duty    = duty_reg;
                    out_next.freq_estimate = freq_reg;
                    out_next.clamped       = clamp_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            prop_reg   <= espc_pkg::PROP_RST;
            kint_reg   <= espc_pkg::INTEG_RST;
            base_reg   <= espc_pkg::BASE_RST;
            weight_reg <= espc_pkg::WEIGHT_RST;
            ppr_reg    <= espc_pkg::PPR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                espc_pkg::REG_TARGET: target_reg <= cfg_data;
                espc_pkg::REG_PROP:   prop_reg   <= cfg_data[19:0];
                espc_pkg::REG_INTEG:  kint_reg   <= cfg_data[19:0];
                espc_pkg::REG_BASE:   base_reg   <= cfg_data[15:0];
                espc_pkg::REG_WEIGHT: weight_reg <= cfg_data[15:0];
                espc_pkg::REG_PPR:    ppr_reg    <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_pulse_reg <= '0;
            avg_reg        <= '0;
            skip_reg       <= '0;
            good_reg       <= '0;
            prev_part_reg  <= '0;
            freq_reg       <= '0;
            prev_err_reg   <= '0;
            integ_reg      <= '0;
            last_step_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_pulse_reg <= last_pulse_next;
            avg_reg        <= avg_next;
            skip_reg       <= skip_next;
            good_reg       <= good_next;
            prev_part_reg  <= prev_part_next;
            freq_reg       <= freq_next;
            prev_err_reg   <= prev_err_next;
            integ_reg      <= integ_next;
            last_step_reg  <= last_step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        win_reg     <= win_next;
        part_reg    <= part_next;
        cnt_neg_reg <= cnt_neg_next;
        cnt_mag_reg <= cnt_mag_next;
        den_reg     <= den_next;
        e_reg       <= e_next;
        sum_neg_reg <= sum_neg_next;
        cand_reg    <= cand_next;
        duty_reg    <= duty_next;
        clamp_reg   <= clamp_next;
        out_reg     <= out_next;
    end
endmodule
